// ----- design/nibble_rle_cel_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// nibble_rle_cel_decoder_macros
// Assertion macros for the cel decoder; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_RLE_CEL_DECODER_MACROS_SVH
`define NIBBLE_RLE_CEL_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define NRCD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nrcd: implication check failed");
// next-cycle implication
`define NRCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nrcd: next-cycle check failed");
`else
`define NRCD_ASSERT_IMPL(lbl, ante, cons)
`define NRCD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- design/nrcd_pkg.sv -----
// ----------------------------------------------------------------------------
// nrcd_pkg
// Types and constants of the nibble run-length cel decoder.
// ----------------------------------------------------------------------------
package nrcd_pkg;

  localparam int DATA_W      = 8;
  localparam int POS_W       = 30;
  localparam int DIM_W       = 16;
  localparam int KIND_W      = 3;
  localparam int ERR_W       = 2;
  localparam int OUT_TDATA_W = POS_W + DATA_W + 2 * DIM_W + 2 * DATA_W + ERR_W;

  // header byte order: width lo/hi, height lo/hi, hot x, hot y, key
  localparam logic [2:0] HDR_WIDTH_LO  = 3'd0;
  localparam logic [2:0] HDR_WIDTH_HI  = 3'd1;
  localparam logic [2:0] HDR_HEIGHT_LO = 3'd2;
  localparam logic [2:0] HDR_HEIGHT_HI = 3'd3;
  localparam logic [2:0] HDR_HOT_X     = 3'd4;
  localparam logic [2:0] HDR_HOT_Y     = 3'd5;
  localparam logic [2:0] HDR_KEY       = 3'd6;

  // positive dimensions fit 15 bits, so the product takes 15 shift-add steps
  localparam logic [3:0] MUL_LAST_STEP = 4'd14;

  localparam logic [KIND_W-1:0] KIND_HEADER   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PIXEL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_COMPLETE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EARLY    = 3'd4;

  localparam logic [ERR_W-1:0] ERR_CODE_DIM = 2'd0;
  localparam logic [ERR_W-1:0] ERR_CODE_RUN = 2'd1;
  localparam logic [ERR_W-1:0] ERR_CODE_HDR = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RUN,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_MUL,
    ST_CHK,
    ST_PIX,
    ST_TAIL
  } seq_state_t;

  // trailing result that closes the work on one byte
  typedef enum logic [2:0] {
    TL_NONE,
    TL_COMPLETE,
    TL_EARLY,
    TL_ERR_DIM,
    TL_ERR_RUN,
    TL_ERR_HDR
  } tail_t;

endpackage

// ----- design/nibble_rle_cel_decoder.sv -----
// Header bytes 1 to 6 are stored; an end_of_cel that cuts the header short adds an error beat.
// Header byte 7: header beat, then an error beat, or 15 multiply steps for
// width*height on the shared 31-bit adder and an optional trailing beat.
// Run byte: a check state on the same adder, one pixel beat per cycle unless the output
// stalls, and a trailing beat when due. Synchronous active-low reset
// returns to the header phase and sets transparent_index to 255.
// ----------------------------------------------------------------------------
// nibble_rle_cel_decoder
// Expands a 4-bit-count / 4-bit-color run-length sprite cel into pixel beats.
// ----------------------------------------------------------------------------
`include "nibble_rle_cel_decoder_macros.svh"

module nibble_rle_cel_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [nrcd_pkg::DATA_W-1:0]          cfg_wdata,   // transparent_index
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [nrcd_pkg::DATA_W-1:0]          in_tdata,    // data_byte
  input  logic                                 in_tlast,    // end_of_cel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pixel_pos, pixel_color, cel_width, cel_height, hot_x, hot_y, error_code
  output logic [nrcd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [nrcd_pkg::KIND_W-1:0]          out_tuser,   // kind
  output logic                                 out_tlast    // last
);

  nrcd_pkg::seq_state_t state_r, state_nxt;
  nrcd_pkg::phase_t     phase_r, phase_nxt;
  nrcd_pkg::tail_t      tail_r, tail_nxt, chk_tail;

  logic [2:0]                      hdr_idx_r, hdr_idx_nxt;
  logic [nrcd_pkg::DIM_W-1:0]      width_r, width_nxt;
  logic [nrcd_pkg::DIM_W-1:0]      height_r, height_nxt;
  logic [nrcd_pkg::DATA_W-1:0]     hotx_r, hotx_nxt;
  logic [nrcd_pkg::DATA_W-1:0]     hoty_r, hoty_nxt;
  logic [nrcd_pkg::DATA_W-1:0]     key_r, key_nxt;
  logic [nrcd_pkg::DATA_W-1:0]     tidx_r;
  logic [nrcd_pkg::POS_W-1:0]      total_r, total_nxt;
  logic [nrcd_pkg::POS_W-1:0]      wpos_r, wpos_nxt;
  logic [3:0]                      cnt_r, cnt_nxt;
  logic [3:0]                      step_r, step_nxt;
  logic [nrcd_pkg::DATA_W-1:0]     color_r, color_nxt;
  logic                            eoc_r, eoc_nxt;

  logic                            out_tvalid_r;
  logic [nrcd_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [nrcd_pkg::KIND_W-1:0]     out_tuser_r;
  logic                            out_tlast_r;

  logic                            in_acc;
  logic                            out_free;
  logic                            emit;
  logic [nrcd_pkg::KIND_W-1:0]     o_kind;
  logic [nrcd_pkg::POS_W-1:0]      o_pos;
  logic [nrcd_pkg::DATA_W-1:0]     o_color;
  logic [nrcd_pkg::DIM_W-1:0]      o_width;
  logic [nrcd_pkg::DIM_W-1:0]      o_height;
  logic [nrcd_pkg::DATA_W-1:0]     o_hotx;
  logic [nrcd_pkg::DATA_W-1:0]     o_hoty;
  logic [nrcd_pkg::ERR_W-1:0]      o_err;
  logic                            o_last;

  logic [nrcd_pkg::POS_W-1:0]      alu_a, alu_b;
  logic [nrcd_pkg::POS_W:0]        alu_sum;
  logic                            dims_bad;
  logic                            run_over;
  logic                            run_full;
  logic [nrcd_pkg::DATA_W-1:0]     color_in;

  assign in_tready  = (state_r == nrcd_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // shared adder: product accumulate, run-end check, position increment
  always_comb begin
    unique case (state_r)
      nrcd_pkg::ST_MUL: begin
        alu_a = total_r;
        alu_b = wpos_r;
      end
      nrcd_pkg::ST_CHK: begin
        alu_a = wpos_r;
        alu_b = {{(nrcd_pkg::POS_W-4){1'b0}}, cnt_r};
      end
      default: begin
        alu_a = wpos_r;
        alu_b = {{(nrcd_pkg::POS_W-1){1'b0}}, 1'b1};
      end
    endcase
    alu_sum = {1'b0, alu_a} + {1'b0, alu_b};
  end

  assign dims_bad = width_r[nrcd_pkg::DIM_W-1] || (width_r == '0) ||
                    height_r[nrcd_pkg::DIM_W-1] || (height_r == '0);
  assign run_over = alu_sum > {1'b0, total_r};
  assign run_full = (alu_sum[nrcd_pkg::POS_W-1:0] == total_r) && !run_over;
  assign color_in = {4'b0000, in_tdata[3:0]};

  always_comb begin
    if (run_full) begin
      chk_tail = nrcd_pkg::TL_COMPLETE;
    end else if (eoc_r) begin
      chk_tail = nrcd_pkg::TL_EARLY;
    end else begin
      chk_tail = nrcd_pkg::TL_NONE;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nrcd_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (phase_r)
            nrcd_pkg::PH_HEADER: begin
              if (hdr_idx_r == nrcd_pkg::HDR_KEY) state_nxt = nrcd_pkg::ST_HDR;
              else if (in_tlast)                  state_nxt = nrcd_pkg::ST_TAIL;
            end
            nrcd_pkg::PH_RUN: state_nxt = nrcd_pkg::ST_CHK;
            default:          state_nxt = nrcd_pkg::ST_IDLE;
          endcase
        end
      end
      nrcd_pkg::ST_HDR: begin
        if (out_free) begin
          state_nxt = (tail_r == nrcd_pkg::TL_ERR_DIM) ? nrcd_pkg::ST_TAIL : nrcd_pkg::ST_MUL;
        end
      end
      nrcd_pkg::ST_MUL: begin
        if (step_r == nrcd_pkg::MUL_LAST_STEP) begin
          state_nxt = (tail_r == nrcd_pkg::TL_NONE) ? nrcd_pkg::ST_IDLE : nrcd_pkg::ST_TAIL;
        end
      end
      nrcd_pkg::ST_CHK: begin
        if (run_over)                          state_nxt = nrcd_pkg::ST_TAIL;
        else if (cnt_r != 4'd0)                state_nxt = nrcd_pkg::ST_PIX;
        else if (chk_tail != nrcd_pkg::TL_NONE) state_nxt = nrcd_pkg::ST_TAIL;
        else                                   state_nxt = nrcd_pkg::ST_IDLE;
      end
      nrcd_pkg::ST_PIX: begin
        if (out_free && cnt_r == 4'd1) begin
          state_nxt = (tail_r == nrcd_pkg::TL_NONE) ? nrcd_pkg::ST_IDLE : nrcd_pkg::ST_TAIL;
        end
      end
      nrcd_pkg::ST_TAIL: begin
        if (out_free) state_nxt = nrcd_pkg::ST_IDLE;
      end
      default: state_nxt = nrcd_pkg::ST_IDLE;
    endcase
  end

  // datapath and result beats
  always_comb begin
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    hotx_nxt    = hotx_r;
    hoty_nxt    = hoty_r;
    key_nxt     = key_r;
    total_nxt   = total_r;
    wpos_nxt    = wpos_r;
    cnt_nxt     = cnt_r;
    step_nxt    = step_r;
    color_nxt   = color_r;
    eoc_nxt     = eoc_r;
    tail_nxt    = tail_r;
    emit        = 1'b0;
    o_kind      = nrcd_pkg::KIND_HEADER;
    o_pos       = '0;
    o_color     = '0;
    o_width     = '0;
    o_height    = '0;
    o_hotx      = '0;
    o_hoty      = '0;
    o_err       = '0;
    o_last      = 1'b0;

    unique case (state_r)
      nrcd_pkg::ST_IDLE: begin
        if (in_acc) begin
          eoc_nxt = in_tlast;
          unique case (phase_r)
            nrcd_pkg::PH_HEADER: begin
              unique case (hdr_idx_r)
                nrcd_pkg::HDR_WIDTH_LO:  width_nxt[7:0]   = in_tdata;
                nrcd_pkg::HDR_WIDTH_HI:  width_nxt[15:8]  = in_tdata;
                nrcd_pkg::HDR_HEIGHT_LO: height_nxt[7:0]  = in_tdata;
                nrcd_pkg::HDR_HEIGHT_HI: height_nxt[15:8] = in_tdata;
                nrcd_pkg::HDR_HOT_X:     hotx_nxt         = in_tdata;
                nrcd_pkg::HDR_HOT_Y:     hoty_nxt         = in_tdata;
                default:                 key_nxt          = in_tdata;
              endcase
              if (hdr_idx_r == nrcd_pkg::HDR_KEY) begin
                hdr_idx_nxt = '0;
                if (dims_bad)      tail_nxt = nrcd_pkg::TL_ERR_DIM;
                else if (in_tlast) tail_nxt = nrcd_pkg::TL_EARLY;
                else               tail_nxt = nrcd_pkg::TL_NONE;
                if (in_tlast)      phase_nxt = nrcd_pkg::PH_HEADER;
                else if (dims_bad) phase_nxt = nrcd_pkg::PH_DONE;
                else               phase_nxt = nrcd_pkg::PH_RUN;
              end else if (in_tlast) begin
                hdr_idx_nxt = '0;
                tail_nxt    = nrcd_pkg::TL_ERR_HDR;
              end else begin
                hdr_idx_nxt = hdr_idx_r + 3'd1;
              end
            end
            nrcd_pkg::PH_RUN: begin
              cnt_nxt   = in_tdata[7:4];
              color_nxt = (color_in == key_r) ? tidx_r : color_in;
            end
            default: begin
              if (in_tlast) begin
                phase_nxt   = nrcd_pkg::PH_HEADER;
                hdr_idx_nxt = '0;
              end
            end
          endcase
        end
      end
      nrcd_pkg::ST_HDR: begin
        if (out_free) begin
          emit     = 1'b1;
          o_kind   = nrcd_pkg::KIND_HEADER;
          o_width  = width_r;
          o_height = height_r;
          o_hotx   = hotx_r;
          o_hoty   = hoty_r;
          o_last   = (tail_r == nrcd_pkg::TL_NONE);
          // multiplicand rides in the position register until the product is done
          wpos_nxt  = {{(nrcd_pkg::POS_W-nrcd_pkg::DIM_W){1'b0}}, width_r};
          total_nxt = '0;
          step_nxt  = '0;
        end
      end
      nrcd_pkg::ST_MUL: begin
        if (height_r[step_r]) total_nxt = alu_sum[nrcd_pkg::POS_W-1:0];
        wpos_nxt = {wpos_r[nrcd_pkg::POS_W-2:0], 1'b0};
        step_nxt = step_r + 4'd1;
        if (step_r == nrcd_pkg::MUL_LAST_STEP) wpos_nxt = '0;
      end
      nrcd_pkg::ST_CHK: begin
        tail_nxt = run_over ? nrcd_pkg::TL_ERR_RUN : chk_tail;
        if (eoc_r)                     phase_nxt = nrcd_pkg::PH_HEADER;
        else if (run_over || run_full) phase_nxt = nrcd_pkg::PH_DONE;
        else                           phase_nxt = nrcd_pkg::PH_RUN;
      end
      nrcd_pkg::ST_PIX: begin
        if (out_free) begin
          emit     = 1'b1;
          o_kind   = nrcd_pkg::KIND_PIXEL;
          o_pos    = wpos_r;
          o_color  = color_r;
          o_last   = (cnt_r == 4'd1) && (tail_r == nrcd_pkg::TL_NONE);
          wpos_nxt = alu_sum[nrcd_pkg::POS_W-1:0];
          cnt_nxt  = cnt_r - 4'd1;
        end
      end
      nrcd_pkg::ST_TAIL: begin
        if (out_free) begin
          emit   = 1'b1;
          o_last = 1'b1;
          unique case (tail_r)
            nrcd_pkg::TL_COMPLETE: o_kind = nrcd_pkg::KIND_COMPLETE;
            nrcd_pkg::TL_ERR_DIM: begin
              o_kind = nrcd_pkg::KIND_ERROR;
              o_err  = nrcd_pkg::ERR_CODE_DIM;
            end
            nrcd_pkg::TL_ERR_RUN: begin
              o_kind = nrcd_pkg::KIND_ERROR;
              o_err  = nrcd_pkg::ERR_CODE_RUN;
            end
            nrcd_pkg::TL_ERR_HDR: begin
              o_kind = nrcd_pkg::KIND_ERROR;
              o_err  = nrcd_pkg::ERR_CODE_HDR;
            end
            default: o_kind = nrcd_pkg::KIND_EARLY;
          endcase
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nrcd_pkg::ST_IDLE;
      phase_r      <= nrcd_pkg::PH_HEADER;
      hdr_idx_r    <= '0;
      tail_r       <= nrcd_pkg::TL_NONE;
      tidx_r       <= '1;
      width_r      <= '0;
      height_r     <= '0;
      key_r        <= '0;
      total_r      <= '0;
      wpos_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      tail_r    <= tail_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      key_r     <= key_nxt;
      total_r   <= total_nxt;
      wpos_r    <= wpos_nxt;
      if (cfg_we) tidx_r <= cfg_wdata;
      if (emit)            out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    hotx_r  <= hotx_nxt;
    hoty_r  <= hoty_nxt;
    cnt_r   <= cnt_nxt;
    step_r  <= step_nxt;
    color_r <= color_nxt;
    eoc_r   <= eoc_nxt;
    if (emit) begin
      out_tdata_r <= {o_err, o_hoty, o_hotx, o_height, o_width, o_color, o_pos};
      out_tuser_r <= o_kind;
      out_tlast_r <= o_last;
    end
  end

  `NRCD_ASSERT_IMPL(a_pix_cnt_nonzero, state_r == nrcd_pkg::ST_PIX, cnt_r != 4'd0)
  `NRCD_ASSERT_IMPL(a_pix_in_range,
                    out_tvalid_r && out_tuser_r == nrcd_pkg::KIND_PIXEL,
                    out_tdata_r[nrcd_pkg::POS_W-1:0] < total_r)
  `NRCD_ASSERT_IMPL(a_wpos_bound,
                    state_r == nrcd_pkg::ST_IDLE && phase_r == nrcd_pkg::PH_RUN,
                    wpos_r <= total_r)
  `NRCD_ASSERT_IMPL(a_mul_tail, state_r == nrcd_pkg::ST_MUL,
                    tail_r == nrcd_pkg::TL_NONE || tail_r == nrcd_pkg::TL_EARLY)
  `NRCD_ASSERT_IMPL(a_error_is_last,
                    out_tvalid_r && out_tuser_r == nrcd_pkg::KIND_ERROR, out_tlast_r)
  `NRCD_ASSERT_NEXT(a_run_goes_check, in_acc && phase_r == nrcd_pkg::PH_RUN,
                    state_r == nrcd_pkg::ST_CHK)

endmodule

// ----- dv/nrcd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrcd_checker
// Watches the byte and result streams of the cel decoder, expands every
// accepted byte into the result beats it should cause, and compares each
// accepted result beat against the oldest outstanding one.
// ----------------------------------------------------------------------------
module nrcd_checker
  import nrcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [DATA_W-1:0]      cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [DATA_W-1:0]      in_tdata,    // data_byte
  input  logic                   in_tlast,    // end_of_cel
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // pixel_pos, pixel_color, cel_width, cel_height, hot_x, hot_y, error_code
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [KIND_W-1:0]      out_tuser,   // kind
  input  logic                   out_tlast,   // last
  output int                     mismatches,
  output int                     pending,
  output int                     beats_checked
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] color;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [DATA_W-1:0] hx;
    logic [DATA_W-1:0] hy;
    logic [ERR_W-1:0]  err;
    logic              last;
  } cel_beat_t;

  phase_t            phase;
  logic [2:0]        hdr_idx;
  logic [DIM_W-1:0]  w_reg;
  logic [DIM_W-1:0]  h_reg;
  logic [DATA_W-1:0] hx_reg;
  logic [DATA_W-1:0] hy_reg;
  logic [DATA_W-1:0] key_reg;
  logic [DATA_W-1:0] tidx;
  logic [POS_W-1:0]  total;
  logic [POS_W-1:0]  wpos;
  cel_beat_t         beats_due[$];
  cel_beat_t         got;
  cel_beat_t         want;

  function automatic cel_beat_t blank_beat(input logic [KIND_W-1:0] kind);
    cel_beat_t bt;
    bt = '0;
    bt.kind = kind;
    return bt;
  endfunction

  // one byte in, zero or more beats appended to beats_due
  task automatic expand_byte(input logic [DATA_W-1:0] b, input logic eoc);
    cel_beat_t         burst[$];
    cel_beat_t         bt;
    logic [31:0]       reach;
    logic [3:0]        cnt;
    logic [DATA_W-1:0] color;
    case (phase)
      PH_HEADER: begin
        case (hdr_idx)
          HDR_WIDTH_LO:  w_reg[7:0]  = b;
          HDR_WIDTH_HI:  w_reg[15:8] = b;
          HDR_HEIGHT_LO: h_reg[7:0]  = b;
          HDR_HEIGHT_HI: h_reg[15:8] = b;
          HDR_HOT_X:     hx_reg      = b;
          HDR_HOT_Y:     hy_reg      = b;
          default:       key_reg     = b;
        endcase
        if (hdr_idx == HDR_KEY) begin
          hdr_idx = '0;
          bt = blank_beat(KIND_HEADER);
          bt.w  = w_reg;
          bt.h  = h_reg;
          bt.hx = hx_reg;
          bt.hy = hy_reg;
          burst.push_back(bt);
          if ($signed(w_reg) <= 0 || $signed(h_reg) <= 0) begin
            bt = blank_beat(KIND_ERROR);
            bt.err = ERR_CODE_DIM;
            burst.push_back(bt);
            phase = PH_DONE;
          end else begin
            total = POS_W'(32'(w_reg) * 32'(h_reg));
            wpos  = '0;
            phase = PH_RUN;
            if (eoc) burst.push_back(blank_beat(KIND_EARLY));
          end
        end else begin
          hdr_idx = hdr_idx + 3'd1;
          if (eoc) begin
            hdr_idx = '0;
            bt = blank_beat(KIND_ERROR);
            bt.err = ERR_CODE_HDR;
            burst.push_back(bt);
          end
        end
      end
      PH_RUN: begin
        cnt   = b[7:4];
        color = {4'h0, b[3:0]};
        // keys above 15 can never equal a 4-bit color
        if (color == key_reg) color = tidx;
        reach = 32'(wpos) + 32'(cnt);
        if (reach > 32'(total)) begin
          bt = blank_beat(KIND_ERROR);
          bt.err = ERR_CODE_RUN;
          burst.push_back(bt);
          phase = PH_DONE;
        end else begin
          for (int i = 0; i < cnt; i++) begin
            bt = blank_beat(KIND_PIXEL);
            bt.pos   = wpos + POS_W'(i);
            bt.color = color;
            burst.push_back(bt);
          end
          wpos = POS_W'(reach);
          if (wpos == total) begin
            burst.push_back(blank_beat(KIND_COMPLETE));
            phase = PH_DONE;
          end else if (eoc) begin
            burst.push_back(blank_beat(KIND_EARLY));
          end
        end
      end
      default: ;
    endcase
    if (eoc) begin
      phase   = PH_HEADER;
      hdr_idx = '0;
    end
    if (burst.size() > 0) begin
      bt = burst.pop_back();
      bt.last = 1'b1;
      burst.push_back(bt);
    end
    foreach (burst[i]) beats_due.push_back(burst[i]);
  endtask

  task automatic note_mismatch(input cel_beat_t exp_b, input cel_beat_t act_b, input bit stray);
    if (mismatches < 10) begin
      if (stray)
        $display("[%0t] result beat with nothing outstanding", $realtime);
      $display("[%0t] exp kind=%0d pos=%0d color=%h w=%0d h=%0d hx=%0d hy=%0d err=%0d last=%b",
               $realtime, exp_b.kind, exp_b.pos, exp_b.color, $signed(exp_b.w),
               $signed(exp_b.h), $signed(exp_b.hx), $signed(exp_b.hy), exp_b.err, exp_b.last);
      $display("[%0t] got kind=%0d pos=%0d color=%h w=%0d h=%0d hx=%0d hy=%0d err=%0d last=%b",
               $realtime, act_b.kind, act_b.pos, act_b.color, $signed(act_b.w),
               $signed(act_b.h), $signed(act_b.hx), $signed(act_b.hy), act_b.err, act_b.last);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase   = PH_HEADER;
      hdr_idx = '0;
      w_reg   = '0;
      h_reg   = '0;
      hx_reg  = '0;
      hy_reg  = '0;
      key_reg = '0;
      total   = '0;
      wpos    = '0;
      tidx    = 8'hff;
      beats_due.delete();
    end else begin
      if (cfg_we) tidx = cfg_wdata;
      if (in_tvalid && in_tready) expand_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.last = out_tlast;
        {got.err, got.hy, got.hx, got.h, got.w, got.color, got.pos} = out_tdata;
        beats_checked++;
        if (beats_due.size() == 0) begin
          note_mismatch('0, got, 1'b1);
        end else begin
          want = beats_due.pop_front();
          if (got !== want) note_mismatch(want, got, 1'b0);
        end
      end
    end
    pending = beats_due.size();
  end

endmodule

// ----- dv/nibble_rle_cel_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nibble_rle_cel_decoder_tb
// Drives cel byte streams into the decoder: a handful of hand-built cels,
// then random cels, mostly well formed with random runs, plus truncated
// headers, bad dimensions and noise, under random gaps and output stalls.
// ----------------------------------------------------------------------------
module nibble_rle_cel_decoder_tb;
  import nrcd_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int RST_CYC    = 11;
  localparam int DRAIN_CYC  = 40;
  localparam int LONG_HOLD  = 300;
  localparam int PHASE_LEN  = 58;

  // shapes of well-formed random cels
  localparam int CEL_COMPLETE = 0;
  localparam int CEL_EARLY    = 1;
  localparam int CEL_OVERRUN  = 2;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [DATA_W-1:0]      cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]      out_tuser;
  logic                   out_tlast;

  int mismatches;
  int pending;
  int beats_checked;
  int n_bytes;
  int n_counted;
  int n_cels;
  int n_settings;
  bit no_gaps;
  bit hold_req;

  nibble_rle_cel_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  nrcd_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .mismatches    (mismatches),
    .pending       (pending),
    .beats_checked (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // result side: random stall per beat, one long hold-off on request
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      stall = no_gaps ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eoc, input bit counted);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eoc;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    n_bytes++;
    if (counted) n_counted++;
    if (eoc) n_cels++;
  endtask

  task automatic send_header(input logic [15:0] w, input logic [15:0] h, input logic [7:0] hx,
                             input logic [7:0] hy, input logic [7:0] key, input logic eoc);
    send_byte(w[7:0], 1'b0, 1'b1);
    send_byte(w[15:8], 1'b0, 1'b1);
    send_byte(h[7:0], 1'b0, 1'b1);
    send_byte(h[15:8], 1'b0, 1'b1);
    send_byte(hx, 1'b0, 1'b1);
    send_byte(hy, 1'b0, 1'b1);
    send_byte(key, eoc, 1'b1);
  endtask

  // ignored bytes after a finished cel, closed by end_of_cel
  task automatic send_tail();
    int unsigned n;
    n = $urandom_range(0, 2);
    repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  // stop offering bytes and wait until the decoder has gone quiet
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_transparent(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic random_cel();
    int unsigned pick, w, h, remaining, cnt, max_cnt, mode, stop_after, runs, n;
    bit          big_cel, eoc, closed;
    logic [7:0]  key;
    logic [3:0]  clr;
    logic [15:0] bad, other;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      big_cel = ($urandom_range(0, 19) == 0);
      w = big_cel ? $urandom_range(1, 32767) : $urandom_range(1, 8);
      h = big_cel ? $urandom_range(1, 32767) : $urandom_range(1, 6);
      if (big_cel && $urandom_range(0, 1)) begin
        w = 32767;
        h = 32767;
      end
      key = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 255))
                                        : 8'($urandom_range(0, 15));
      eoc = ($urandom_range(0, 24) == 0);
      send_header(16'(w), 16'(h), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  key, eoc);
      closed = eoc;
      remaining = w * h;
      pick = $urandom_range(0, 9);
      mode = big_cel ? CEL_EARLY : (pick < 6) ? CEL_COMPLETE : (pick < 8) ? CEL_EARLY
                                                                          : CEL_OVERRUN;
      stop_after = $urandom_range(1, 6);
      runs = 0;
      while (!closed && remaining > 0) begin
        clr = ($urandom_range(0, 3) == 0) ? key[3:0] : 4'($urandom_range(0, 15));
        if (mode == CEL_OVERRUN && remaining < 15) begin
          // run longer than what is left: error, cel done
          cnt = $urandom_range(remaining + 1, 15);
          eoc = ($urandom_range(0, 3) == 0);
          send_byte({4'(cnt), clr}, eoc, 1'b1);
          closed = eoc;
          remaining = 0;
        end else begin
          max_cnt = (remaining < 15) ? remaining : 15;
          cnt = $urandom_range(0, max_cnt);
          runs++;
          eoc = (mode == CEL_EARLY && runs == stop_after) ||
                (cnt == remaining && $urandom_range(0, 1));
          send_byte({4'(cnt), clr}, eoc, 1'b1);
          closed = eoc;
          remaining = remaining - cnt;
        end
      end
      if (!closed) send_tail();
    end else if (pick < 85) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), i == n - 1, 1'b1);
    end else if (pick < 95) begin
      bad   = $urandom_range(0, 1) ? 16'h0000 : 16'($urandom_range(32768, 65535));
      other = 16'($urandom_range(0, 65535));
      eoc   = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 1))
        send_header(bad, other, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), eoc);
      else
        send_header(other, bad, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), eoc);
      if (!eoc) send_tail();
    end else begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 7) == 0), 1'b1);
    end
  endtask

  initial begin
    int unsigned quota;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    no_gaps   = 1'b0;
    hold_req  = 1'b0;
    n_settings = 1;
    repeat (RST_CYC) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 3x1, keyed pixels under the reset index, a zero run, completing run with end
    send_header(16'd3, 16'd1, 8'h80, 8'h7f, 8'h05, 1'b0);
    send_byte(8'h25, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h1a, 1'b1, 1'b1);
    // header cut short
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h80, 1'b1, 1'b1);
    // zero width, most negative height, end on the key byte
    send_header(16'h0000, 16'h8000, 8'h00, 8'h00, 8'h00, 1'b1);
    // largest dimensions, key out of range, full run, zero run ends the cel
    send_header(16'h7fff, 16'h7fff, 8'h00, 8'hff, 8'h1f, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);

    for (int p = 0; p < 5; p++) begin
      wait_quiet();
      write_transparent(p == 0 ? 8'h00 : p == 1 ? 8'hff : 8'($urandom_range(0, 255)));
      no_gaps = (p == 2);
      if (p == 3) hold_req = 1'b1;
      quota = n_counted + PHASE_LEN;
      while (n_counted < quota) random_cel();
    end
    no_gaps = 1'b0;
    wait_quiet();

    $display("covered %0d bytes in %0d cels under %0d transparent_index settings",
             n_bytes, n_cels, n_settings);
    $display("checked %0d result beats", beats_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
